// File: hw/rtl/working_set_thrashing_control_assert.svh
// assertion macros for the working-set load control block
// clocked on clk, disabled while rst_n is low
`ifndef WORKING_SET_THRASHING_CONTROL_ASSERT_SVH
`define WORKING_SET_THRASHING_CONTROL_ASSERT_SVH

// expression holds at every edge
`define WSTC_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define WSTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wstc_pkg.sv
// shared types and constants of the working-set load control block
// no dependencies
package wstc_pkg;

  localparam int TFW    = 17;  // total_frames and admitted_demand width
  localparam int CPW    = 16;  // check_period width
  localparam int MASK_W = 16;  // slot masks in the result transaction
  localparam int CFG_IW = 1;   // configuration register index width

  localparam logic [TFW-1:0] DEMAND_MAX       = '1;
  localparam logic [TFW-1:0] TOTAL_FRAMES_RST = 17'd1024;
  localparam logic [CPW-1:0] CHECK_PERIOD_RST = 16'd50;

  // request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_PAGE     = 2'd1;
  localparam logic [1:0] REQ_PRESENCE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_TOTAL_FRAMES = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_CHECK_PERIOD = 1'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] process_slot;
    logic       present_value;
  } in_item_t;

  typedef struct packed {
    logic              check_done;
    logic [MASK_W-1:0] suspended_mask;
    logic [MASK_W-1:0] woken_mask;
    logic [MASK_W-1:0] newly_suspended_mask;
    logic [TFW-1:0]    admitted_demand;
  } out_item_t;

endpackage

// File: hw/rtl/wstc_cnt_mem.sv
// working-set page count memory: one write port, one read port,
// read data registered; no dependencies
module wstc_cnt_mem #(
  parameter int  DEPTH = 16,
  parameter int  DW    = 13,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/working_set_thrashing_control.sv
// working-set load control, top level; uses wstc_pkg and wstc_cnt_mem
// tick without evaluation, presence and unused codes: result registered directly; page access: count read, then
//   written back incremented in ST_INC with the result; evaluation tick: one sum sweep and one
//   adjust/clear sweep over the count memory, one read port entry per cycle
// one transaction in flight; a new one is taken only while the output register is free or draining
// reset: rst_n synchronous, active low; the count memory is not cleared, creation writes 0
`include "working_set_thrashing_control_assert.svh"

module working_set_thrashing_control #(
  parameter int MAX_SLOTS    = 16,
  parameter int MAX_WS_PAGES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wstc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wstc_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [wstc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wstc_pkg::TFW-1:0]    cfg_wdata
);

  import wstc_pkg::*;

  localparam int CW   = $clog2(MAX_WS_PAGES + 1);
  localparam int SIW  = $clog2(MAX_SLOTS);
  localparam int SW   = ((CW + SIW) > TFW ? (CW + SIW) : TFW) + 1;
  localparam int PW   = MAX_SLOTS > MASK_W ? MAX_SLOTS : MASK_W;
  localparam logic [SIW-1:0] LAST   = SIW'(MAX_SLOTS - 1);
  localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_WS_PAGES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INC  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_ADJ  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [MAX_SLOTS-1:0] pres_r, pres_nxt;
  logic [MAX_SLOTS-1:0] susp_r, susp_nxt;
  logic [MAX_SLOTS-1:0] wk_r, wk_nxt;
  logic [MAX_SLOTS-1:0] ns_r, ns_nxt;
  logic [CPW-1:0]       cnt_r, cnt_nxt;
  logic [TFW-1:0]       total_frames_r;
  logic [CPW-1:0]       check_period_r;
  logic [SW-1:0]        sum_r, sum_nxt;
  logic [SIW-1:0]       ptr_r, ptr_nxt;
  logic [SIW-1:0]       ridx_r, ridx_nxt;
  logic [SIW-1:0]       slot_r, slot_nxt;
  logic                 issue_r, issue_nxt;
  logic                 rvld_r, rvld_nxt;
  logic                 fit_r, fit_nxt;
  logic                 stop_r, stop_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r, res;

  logic                 in_fire, slot_ok, load_out, eval_done;
  logic [SIW-1:0]       slot_idx;
  logic                 mem_we, mem_re;
  logic [SIW-1:0]       mem_waddr, mem_raddr;
  logic [CW-1:0]        mem_wdata, mem_rdata;
  logic [SW-1:0]        tf_ext, rd_ext, wake_sum, drop_sum;
  logic [PW-1:0]        susp_pad, wk_pad, ns_pad;

  wstc_cnt_mem #(
    .DEPTH (MAX_SLOTS),
    .DW    (CW)
  ) u_cnt_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign slot_ok   = 32'(in_data.process_slot) < MAX_SLOTS;
  assign slot_idx  = SIW'(in_data.process_slot);
  assign tf_ext    = SW'(total_frames_r);
  assign rd_ext    = SW'(mem_rdata);
  assign wake_sum  = sum_r + rd_ext;
  assign drop_sum  = sum_r - rd_ext;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    pres_nxt  = pres_r;
    susp_nxt  = susp_r;
    wk_nxt    = wk_r;
    ns_nxt    = ns_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    ptr_nxt   = ptr_r;
    ridx_nxt  = ridx_r;
    slot_nxt  = slot_r;
    issue_nxt = issue_r;
    rvld_nxt  = 1'b0;
    fit_nxt   = fit_r;
    stop_nxt  = stop_r;
    mem_we    = 1'b0;
    mem_waddr = ridx_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = ptr_r;
    load_out  = 1'b0;
    eval_done = 1'b0;

    // sweep address generator shared by both evaluation passes
    if ((state_r == ST_SUM || state_r == ST_ADJ) && issue_r) begin
      mem_re   = 1'b1;
      rvld_nxt = 1'b1;
      ridx_nxt = ptr_r;
      ptr_nxt  = ptr_r + SIW'(1);
      if (ptr_r == LAST) begin
        issue_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.req_type)
            REQ_TICK: begin
              if (cnt_r <= CPW'(1)) begin
                cnt_nxt   = (check_period_r == '0) ? CPW'(1) : check_period_r;
                sum_nxt   = '0;
                wk_nxt    = '0;
                ns_nxt    = '0;
                ptr_nxt   = '0;
                issue_nxt = 1'b1;
                state_nxt = ST_SUM;
              end else begin
                cnt_nxt  = cnt_r - CPW'(1);
                load_out = 1'b1;
              end
            end
            REQ_PAGE: begin
              if (slot_ok && pres_r[slot_idx]) begin
                mem_re    = 1'b1;
                mem_raddr = slot_idx;
                slot_nxt  = slot_idx;
                state_nxt = ST_INC;
              end else begin
                load_out = 1'b1;
              end
            end
            REQ_PRESENCE: begin
              if (slot_ok) begin
                if (!in_data.present_value || !pres_r[slot_idx]) begin
                  pres_nxt[slot_idx] = in_data.present_value;
                  susp_nxt[slot_idx] = 1'b0;
                  mem_we             = 1'b1;
                  mem_waddr          = slot_idx;
                end
              end
              load_out = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end

      ST_INC: begin
        if (mem_rdata < CNT_MAX) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = mem_rdata + CW'(1);
        end
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_SUM: begin
        if (rvld_r && pres_r[ridx_r] && !susp_r[ridx_r]) begin
          sum_nxt = wake_sum;
        end
        if (rvld_r && ridx_r == LAST) begin
          fit_nxt   = sum_nxt <= tf_ext;
          stop_nxt  = 1'b0;
          ptr_nxt   = '0;
          issue_nxt = 1'b1;
          state_nxt = ST_ADJ;
        end
      end

      ST_ADJ: begin
        if (rvld_r) begin
          if (pres_r[ridx_r]) begin
            if (fit_r) begin
              if (susp_r[ridx_r] && wake_sum <= tf_ext) begin
                susp_nxt[ridx_r] = 1'b0;
                wk_nxt[ridx_r]   = 1'b1;
                sum_nxt          = wake_sum;
              end
            end else if (!susp_r[ridx_r] && !stop_r) begin
              susp_nxt[ridx_r] = 1'b1;
              ns_nxt[ridx_r]   = 1'b1;
              sum_nxt          = drop_sum;
              if (drop_sum <= tf_ext) begin
                stop_nxt = 1'b1;
              end
            end
            // slot stays active: its count restarts
            if (!susp_nxt[ridx_r]) begin
              mem_we = 1'b1;
            end
          end
          if (ridx_r == LAST) begin
            eval_done = 1'b1;
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    susp_pad = PW'(susp_nxt);
    wk_pad   = PW'(wk_nxt);
    ns_pad   = PW'(ns_nxt);
    res.check_done           = eval_done;
    res.suspended_mask       = susp_pad[MASK_W-1:0];
    res.woken_mask           = eval_done ? wk_pad[MASK_W-1:0] : '0;
    res.newly_suspended_mask = eval_done ? ns_pad[MASK_W-1:0] : '0;
    if (!eval_done) begin
      res.admitted_demand = '0;
    end else if (sum_nxt > SW'(DEMAND_MAX)) begin
      res.admitted_demand = DEMAND_MAX;
    end else begin
      res.admitted_demand = sum_nxt[TFW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pres_r         <= '0;
      susp_r         <= '0;
      cnt_r          <= CHECK_PERIOD_RST;
      total_frames_r <= TOTAL_FRAMES_RST;
      check_period_r <= CHECK_PERIOD_RST;
      issue_r        <= 1'b0;
      rvld_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pres_r      <= pres_nxt;
      susp_r      <= susp_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= load_out || (out_valid_r && !out_ready);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOTAL_FRAMES: total_frames_r <= cfg_wdata;
          CFG_CHECK_PERIOD: check_period_r <= cfg_wdata[CPW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wk_r   <= wk_nxt;
    ns_r   <= ns_nxt;
    sum_r  <= sum_nxt;
    ptr_r  <= ptr_nxt;
    ridx_r <= ridx_nxt;
    slot_r <= slot_nxt;
    fit_r  <= fit_nxt;
    stop_r <= stop_nxt;
    if (load_out) begin
      out_data_r <= res;
    end
  end

  `WSTC_ASSERT_HOLDS(a_susp_only_present, (susp_r & ~pres_r) == '0, "suspended slot not present")
  `WSTC_ASSERT_HOLDS(a_countdown_nonzero, cnt_r != '0, "tick countdown reached zero")
  `WSTC_ASSERT_IMPL(a_wake_susp_disjoint, out_valid_r, (out_data_r.woken_mask & out_data_r.newly_suspended_mask) == '0, "slot both woken and suspended")
  `WSTC_ASSERT_NEXT(a_eval_gives_result, state_r == ST_ADJ && rvld_r && ridx_r == LAST, out_valid_r && out_data_r.check_done, "evaluation ended without result")
  `WSTC_ASSERT_IMPL(a_quiet_result, out_valid_r && !out_data_r.check_done, out_data_r.woken_mask == '0 && out_data_r.newly_suspended_mask == '0 && out_data_r.admitted_demand == '0, "non-evaluation result carries evaluation data")

endmodule

// File: test/tb_working_set_thrashing_control.sv
// self-checking testbench for working_set_thrashing_control
// depends on wstc_pkg and the block's rtl; predicts every report and compares it field by field
module tb_working_set_thrashing_control;
  timeunit 1ns;
  timeprecision 1ps;

  import wstc_pkg::*;

  localparam int SLOTS  = 16;
  localparam int WS_CAP = 4096;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = CFG_TOTAL_FRAMES;
  logic [TFW-1:0]      cfg_wdata = '0;

  working_set_thrashing_control #(
    .MAX_SLOTS(SLOTS),
    .MAX_WS_PAGES(WS_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the slot table and registers
  logic [SLOTS-1:0] slot_live = '0;
  logic [SLOTS-1:0] slot_held = '0;
  int unsigned      page_count [SLOTS];
  int unsigned      ticks_left = CHECK_PERIOD_RST;
  int unsigned      frames_cfg = TOTAL_FRAMES_RST;
  int unsigned      period_cfg = CHECK_PERIOD_RST;

  in_item_t  requests_to_send [$];
  out_item_t predicted_reports [$];
  int        mismatches = 0;
  int        results_seen = 0;

  function automatic out_item_t apply_request(in_item_t rq);
    out_item_t        rep;
    logic [SLOTS-1:0] woken;
    logic [SLOTS-1:0] newly;
    int unsigned      sum;
    int unsigned      trial;
    int               s;
    bit               fits;
    rep = '0;
    woken = '0;
    newly = '0;
    sum = 0;
    fits = 1'b0;
    s = rq.process_slot;
    case (rq.req_type)
      REQ_TICK: begin
        if (ticks_left <= 1) begin
          ticks_left = (period_cfg == 0) ? 1 : period_cfg;
          for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && !slot_held[i]) sum += page_count[i];
          if (sum <= frames_cfg) begin
            // resume in ascending order each one that still fits
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i] && slot_held[i]) begin
                trial = sum + page_count[i];
                if (trial <= frames_cfg) begin
                  slot_held[i] = 1'b0;
                  woken[i] = 1'b1;
                  sum = trial;
                end
              end
            end
          end else begin
            // suspend in ascending order until the demand fits
            for (int i = 0; i < SLOTS; i++) begin
              if (!fits && slot_live[i] && !slot_held[i] && !woken[i]) begin
                slot_held[i] = 1'b1;
                newly[i] = 1'b1;
                sum -= page_count[i];
                if (sum <= frames_cfg) fits = 1'b1;
              end
            end
          end
          for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && !slot_held[i]) page_count[i] = 0;
          rep.check_done = 1'b1;
          rep.woken_mask = woken;
          rep.newly_suspended_mask = newly;
          rep.admitted_demand = (sum > DEMAND_MAX) ? DEMAND_MAX : sum[TFW-1:0];
        end else begin
          ticks_left--;
        end
      end
      REQ_PAGE: begin
        if (slot_live[s] && page_count[s] < WS_CAP) page_count[s]++;
      end
      REQ_PRESENCE: begin
        if (rq.present_value) begin
          if (!slot_live[s]) begin
            slot_live[s] = 1'b1;
            slot_held[s] = 1'b0;
            page_count[s] = 0;
          end
        end else begin
          slot_live[s] = 1'b0;
          slot_held[s] = 1'b0;
          page_count[s] = 0;
        end
      end
      default: ;
    endcase
    rep.suspended_mask = slot_held;
    return rep;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_reports = {predicted_reports, apply_request(in_data)};
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= requests_to_send.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, one long hold-off
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
        // long hold so the block backs up onto its input
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) >= 3);
          2: out_ready <= ($urandom_range(0, 9) >= 7);
          default: out_ready <= ((rx_cycle % 5) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (predicted_reports.size() == 0) begin
        $error("report transaction with none predicted: %0h", out_data);
        mismatches++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("check_done", want.check_done, out_data.check_done);
        check_field("suspended_mask", want.suspended_mask, out_data.suspended_mask);
        check_field("woken_mask", want.woken_mask, out_data.woken_mask);
        check_field("newly_suspended_mask", want.newly_suspended_mask,
                    out_data.newly_suspended_mask);
        check_field("admitted_demand", want.admitted_demand, out_data.admitted_demand);
      end
    end
  end

  function automatic in_item_t random_request(input int unsigned slot_hi);
    in_item_t    rq;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    rq.process_slot = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, slot_hi));
    rq.present_value = ($urandom_range(0, 3) != 0);
    if (roll < 38) rq.req_type = REQ_TICK;
    else if (roll < 83) rq.req_type = REQ_PAGE;
    else if (roll < 97) rq.req_type = REQ_PRESENCE;
    else rq.req_type = REQ_UNUSED;
    return rq;
  endfunction

  task automatic enqueue_request(input in_item_t rq);
    requests_to_send = {requests_to_send, rq};
  endtask

  task automatic push(input logic [1:0] kind, input int unsigned slot, input bit pv);
    in_item_t rq;
    rq.req_type = kind;
    rq.process_slot = 4'(slot);
    rq.present_value = pv;
    enqueue_request(rq);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [TFW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_TOTAL_FRAMES) frames_cfg = val;
    else period_cfg = val[CPW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_for_drain();
    do @(posedge clk);
    while (requests_to_send.size() != 0 || in_valid || predicted_reports.size() != 0);
  endtask

  task automatic run_phase(input logic [TFW-1:0] frames, input logic [TFW-1:0] period,
                           input int count, input int unsigned slot_hi);
    write_reg(CFG_TOTAL_FRAMES, frames);
    write_reg(CFG_CHECK_PERIOD, period);
    repeat (count) enqueue_request(random_request(slot_hi));
    wait_for_drain();
  endtask

  initial begin
    in_item_t rq;
    foreach (page_count[i]) page_count[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset values of the registers and the countdown
    repeat (150) enqueue_request(random_request(15));
    wait_for_drain();

    // directed: creation, repeated creation, absent access, suspend, resume, removal
    write_reg(CFG_TOTAL_FRAMES, 17'd5);
    write_reg(CFG_CHECK_PERIOD, 17'd2);
    push(REQ_PRESENCE, 0, 1'b1);
    push(REQ_PRESENCE, 1, 1'b1);
    push(REQ_PRESENCE, 15, 1'b1);
    push(REQ_PRESENCE, 1, 1'b1);
    push(REQ_PAGE, 3, 1'b0);
    repeat (3) push(REQ_PAGE, 0, 1'b0);
    repeat (3) push(REQ_PAGE, 1, 1'b1);
    push(REQ_PAGE, 15, 1'b0);
    repeat (2) push(REQ_TICK, 15, 1'b1);
    push(REQ_UNUSED, 15, 1'b1);
    push(REQ_UNUSED, 0, 1'b0);
    repeat (2) push(REQ_TICK, 0, 1'b0);
    push(REQ_PRESENCE, 1, 1'b0);
    push(REQ_PRESENCE, 7, 1'b0);
    repeat (2) push(REQ_TICK, 8, 1'b1);
    push(REQ_PAGE, 1, 1'b0);
    push(REQ_TICK, 0, 1'b0);
    wait_for_drain();

    run_phase(17'd0, 17'd1, 150, 3);
    run_phase(17'd6, 17'd2, 200, 5);
    run_phase(17'd12, 17'd3, 200, 15);
    // zero period, upper write bit beyond the register set
    run_phase(17'd3, 17'h10000, 100, 3);
    run_phase(17'd30, 17'd5, 200, 7);
    run_phase(TFW'($urandom_range(1, 40)), TFW'($urandom_range(1, 6)), 100, 15);

    // no frames: slot 3 stays suspended while its count keeps growing
    write_reg(CFG_TOTAL_FRAMES, 17'd0);
    write_reg(CFG_CHECK_PERIOD, 17'd2);
    push(REQ_PRESENCE, 3, 1'b1);
    repeat (150) begin
      if ($urandom_range(0, 99) < 92) begin
        push(REQ_PAGE, 3, 1'($urandom_range(0, 1)));
      end else begin
        rq = random_request(15);
        rq.req_type = REQ_TICK;
        enqueue_request(rq);
      end
    end
    wait_for_drain();

    // all frames: the suspended slot comes back
    write_reg(CFG_TOTAL_FRAMES, 17'd65536);
    write_reg(CFG_CHECK_PERIOD, 17'd1);
    repeat (2) push(REQ_TICK, 3, 1'b0);
    repeat (30) enqueue_request(random_request(15));
    wait_for_drain();

    run_phase(17'd20, 17'd65535, 40, 15);

    repeat (40) @(posedge clk);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
